// ----- hdl/ngb_pkg.sv -----
// Package for the nibble glyph blitter: opcodes, register indexes and the
// records passed between the front end, the queue and the back end.
// No dependencies.
package ngb_pkg;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FB_WIDTH         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FB_HEIGHT        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_LOW      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_MID_LOW  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_MID_HIGH = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_HIGH     = 3'd5;

   localparam int FB_DIM_WIDTH = 11;
   localparam int ADDR_WIDTH   = 17;
   localparam int COLOR_WIDTH  = 16;

   // Sixteen RGB565 entries, entry 0 in bits 15:0.
   typedef logic [15:0][COLOR_WIDTH-1:0] palette_type;

   // One nibble with its clip result (hit) and its frame coordinates.
   typedef struct packed {
      logic                    hit;
      logic [FB_DIM_WIDTH-1:0] x;
      logic [FB_DIM_WIDTH-1:0] y;
      logic [3:0]              nib;
   } pixel_type;

   // One data byte worth of work: low nibble in p0, high nibble in p1.
   typedef struct packed {
      pixel_type p1;
      pixel_type p0;
   } entry_type;

endpackage

// ----- hdl/nibble_glyph_to_rgb565_blitter_unit.sv -----
// Top level of the A4 glyph blitter: configuration registers, front end,
// queue and back end. Depends on ngb_pkg, ngb_front, ngb_queue, ngb_back.
//
// Usage:
//   req_* carries transactions of two kinds. A header (op 0) sets the glyph
//   origin, size and baseline offset and restarts the pixel position; it
//   produces no write. A data transaction (op 1) brings one byte of two
//   4-bit pixels, low nibble first, in row-major glyph order.
//   rsp_* carries frame-buffer writes: address y*fb_width+x and an RGB565
//   color from the 16-entry palette. rsp_last marks the final write caused
//   by a data byte. Nibbles outside the frame, past the end of the glyph,
//   or in a frame larger than FB_CAPACITY are consumed without a write.
//   csr_* writes fb_width, fb_height and the four palette words; write only
//   while no transaction is in flight.
// Timing:
//   A write passes through the queue and then the output register before it
//   appears on rsp_*; the second write of the byte comes from the same entry.
//   The back end issues one write per cycle while rsp_ready is high, so a byte
//   with two visible pixels holds its queue entry for both writes; the front end
//   takes one transaction per cycle while the two-entry queue has room.
// Reset clears the glyph state, the configuration and the queue. When the
// receiver stalls, the output register holds, the queue fills and then
// req_ready drops.
module nibble_glyph_to_rgb565_blitter_unit #(
   parameter int FB_CAPACITY = 131072
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_op,
   input  logic signed [15:0]                      req_origin_x,
   input  logic signed [15:0]                      req_origin_y,
   input  logic [7:0]                              req_glyph_width,
   input  logic [7:0]                              req_glyph_height,
   input  logic signed [7:0]                       req_baseline_offset,
   input  logic [7:0]                              req_font_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [ngb_pkg::ADDR_WIDTH-1:0]          rsp_pixel_address,
   output logic [ngb_pkg::COLOR_WIDTH-1:0]         rsp_pixel_color,
   output logic                                    rsp_last,
   input  logic                                    csr_we,
   input  logic [ngb_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [63:0]                             csr_wdata
);

   // Configuration registers.
   logic [ngb_pkg::FB_DIM_WIDTH-1:0] fb_width_ff, fb_width_in;
   logic [ngb_pkg::FB_DIM_WIDTH-1:0] fb_height_ff, fb_height_in;
   logic [63:0] pal_low_ff, pal_low_in;
   logic [63:0] pal_mid_low_ff, pal_mid_low_in;
   logic [63:0] pal_mid_high_ff, pal_mid_high_in;
   logic [63:0] pal_high_ff, pal_high_in;

   ngb_pkg::palette_type palette;
   ngb_pkg::entry_type   push_entry;
   ngb_pkg::entry_type   head;
   logic                 push, pop, empty, full;

   always_comb begin
      fb_width_in     = fb_width_ff;
      fb_height_in    = fb_height_ff;
      pal_low_in      = pal_low_ff;
      pal_mid_low_in  = pal_mid_low_ff;
      pal_mid_high_in = pal_mid_high_ff;
      pal_high_in     = pal_high_ff;
      if (csr_we) begin
         case (csr_index)
            ngb_pkg::CSR_FB_WIDTH:
               fb_width_in = csr_wdata[ngb_pkg::FB_DIM_WIDTH-1:0];
            ngb_pkg::CSR_FB_HEIGHT:
               fb_height_in = csr_wdata[ngb_pkg::FB_DIM_WIDTH-1:0];
            ngb_pkg::CSR_PALETTE_LOW:      pal_low_in      = csr_wdata;
            ngb_pkg::CSR_PALETTE_MID_LOW:  pal_mid_low_in  = csr_wdata;
            ngb_pkg::CSR_PALETTE_MID_HIGH: pal_mid_high_in = csr_wdata;
            ngb_pkg::CSR_PALETTE_HIGH:     pal_high_in     = csr_wdata;
            default: begin
               // Drop writes to unmapped indexes.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff     <= '0;
         fb_height_ff    <= '0;
         pal_low_ff      <= '0;
         pal_mid_low_ff  <= '0;
         pal_mid_high_ff <= '0;
         pal_high_ff     <= '0;
      end else begin
         fb_width_ff     <= fb_width_in;
         fb_height_ff    <= fb_height_in;
         pal_low_ff      <= pal_low_in;
         pal_mid_low_ff  <= pal_mid_low_in;
         pal_mid_high_ff <= pal_mid_high_in;
         pal_high_ff     <= pal_high_in;
      end
   end

   // Entry 0 lands in the low 16 bits of the packed palette.
   assign palette = {pal_high_ff, pal_mid_high_ff, pal_mid_low_ff, pal_low_ff};

   ngb_front #(
      .FB_CAPACITY (FB_CAPACITY)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_origin_x        (req_origin_x),
      .req_origin_y        (req_origin_y),
      .req_glyph_width     (req_glyph_width),
      .req_glyph_height    (req_glyph_height),
      .req_baseline_offset (req_baseline_offset),
      .req_font_byte       (req_font_byte),
      .fb_width            (fb_width_ff),
      .fb_height           (fb_height_ff),
      .queue_full          (full),
      .push                (push),
      .push_entry          (push_entry)
   );

   ngb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   ngb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .empty             (empty),
      .pop               (pop),
      .fb_width          (fb_width_ff),
      .palette           (palette),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- hdl/ngb_front.sv -----
// Front end of the glyph blitter: takes header and data transactions,
// tracks the glyph position and clips both nibbles of each byte.
// Depends on ngb_pkg.
module ngb_front #(
   parameter int FB_CAPACITY = 131072
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic signed [15:0]                req_origin_x,
   input  logic signed [15:0]                req_origin_y,
   input  logic [7:0]                        req_glyph_width,
   input  logic [7:0]                        req_glyph_height,
   input  logic signed [7:0]                 req_baseline_offset,
   input  logic [7:0]                        req_font_byte,
   input  logic [ngb_pkg::FB_DIM_WIDTH-1:0]  fb_width,
   input  logic [ngb_pkg::FB_DIM_WIDTH-1:0]  fb_height,
   input  logic                              queue_full,
   output logic                              push,
   output ngb_pkg::entry_type                push_entry
);

   logic signed [15:0] glyph_left_ff, glyph_left_in;
   logic signed [16:0] glyph_top_ff, glyph_top_in;
   logic [7:0]         width_ff, width_in;
   logic [7:0]         height_ff, height_in;
   logic [7:0]         col_ff, col_in;
   logic [7:0]         row_ff, row_in;

   logic        accept;
   logic        active0, active1;
   logic        wrap0, wrap1;
   logic [7:0]  col_a, row_a, col_b, row_b;
   logic signed [16:0] x0, x1;
   logic signed [17:0] y0, y1;
   logic [21:0] area;
   logic        area_ok;
   logic        hit0, hit1;

   function automatic logic in_frame(
      input logic signed [16:0]               x,
      input logic signed [17:0]               y,
      input logic [ngb_pkg::FB_DIM_WIDTH-1:0] w,
      input logic [ngb_pkg::FB_DIM_WIDTH-1:0] h
   );
      logic x_ok, y_ok;
      x_ok = !x[16] && (x[15:0] < {5'd0, w});
      y_ok = !y[17] && (y[16:0] < {6'd0, h});
      return x_ok && y_ok;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // Position of the low nibble is the current counter pair.
      active0 = (row_ff < height_ff) && (width_ff != 8'd0);
      wrap0   = ({1'b0, col_ff} + 9'd1) >= {1'b0, width_ff};
      col_a   = wrap0 ? 8'd0 : col_ff + 8'd1;
      row_a   = wrap0 ? row_ff + 8'd1 : row_ff;

      // High nibble sits one step further, only if the low one was consumed.
      active1 = active0 && (row_a < height_ff);
      wrap1   = ({1'b0, col_a} + 9'd1) >= {1'b0, width_ff};
      col_b   = wrap1 ? 8'd0 : col_a + 8'd1;
      row_b   = wrap1 ? row_a + 8'd1 : row_a;

      x0 = {glyph_left_ff[15], glyph_left_ff} + $signed({9'd0, col_ff});
      y0 = {glyph_top_ff[16], glyph_top_ff} + $signed({10'd0, row_ff});
      x1 = {glyph_left_ff[15], glyph_left_ff} + $signed({9'd0, col_a});
      y1 = {glyph_top_ff[16], glyph_top_ff} + $signed({10'd0, row_a});

      area    = 22'(fb_width) * 22'(fb_height);
      area_ok = {10'd0, area} <= 32'(FB_CAPACITY);

      hit0 = active0 && area_ok && in_frame(x0, y0, fb_width, fb_height);
      hit1 = active1 && area_ok && in_frame(x1, y1, fb_width, fb_height);

      push_entry.p0.hit = hit0;
      push_entry.p0.x   = x0[ngb_pkg::FB_DIM_WIDTH-1:0];
      push_entry.p0.y   = y0[ngb_pkg::FB_DIM_WIDTH-1:0];
      push_entry.p0.nib = req_font_byte[3:0];
      push_entry.p1.hit = hit1;
      push_entry.p1.x   = x1[ngb_pkg::FB_DIM_WIDTH-1:0];
      push_entry.p1.y   = y1[ngb_pkg::FB_DIM_WIDTH-1:0];
      push_entry.p1.nib = req_font_byte[7:4];

      push = accept && (req_op == ngb_pkg::OP_DATA) && (hit0 || hit1);

      glyph_left_in = glyph_left_ff;
      glyph_top_in  = glyph_top_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      if (accept) begin
         if (req_op == ngb_pkg::OP_HEADER) begin
            glyph_left_in = req_origin_x;
            glyph_top_in  = {req_origin_y[15], req_origin_y}
                            + {{9{req_baseline_offset[7]}}, req_baseline_offset};
            width_in      = req_glyph_width;
            height_in     = req_glyph_height;
            col_in        = 8'd0;
            row_in        = 8'd0;
         end else if (active1) begin
            col_in = col_b;
            row_in = row_b;
         end else if (active0) begin
            col_in = col_a;
            row_in = row_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_left_ff <= '0;
         glyph_top_ff  <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         glyph_left_ff <= glyph_left_in;
         glyph_top_ff  <= glyph_top_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

endmodule

// ----- hdl/ngb_queue.sv -----
// Two-entry queue between the glyph front end and the pixel back end.
// Depends on ngb_pkg.
module ngb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ngb_pkg::entry_type push_entry,
   input  logic               pop,
   output ngb_pkg::entry_type head,
   output logic               empty,
   output logic               full
);

   ngb_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/ngb_back.sv -----
// Glyph blitter back end: turns queued nibbles into frame-buffer writes, one
// per cycle unless stalled, through an output register. Depends on ngb_pkg.
module ngb_back (
   input  logic                              clock,
   input  logic                              reset,
   input  ngb_pkg::entry_type                head,
   input  logic                              empty,
   output logic                              pop,
   input  logic [ngb_pkg::FB_DIM_WIDTH-1:0]  fb_width,
   input  ngb_pkg::palette_type              palette,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ngb_pkg::ADDR_WIDTH-1:0]    rsp_pixel_address,
   output logic [ngb_pkg::COLOR_WIDTH-1:0]   rsp_pixel_color,
   output logic                              rsp_last
);

   logic                             valid_ff, valid_in;
   logic                             sel_ff, sel_in;
   logic [ngb_pkg::ADDR_WIDTH-1:0]   addr_ff, addr_in;
   logic [ngb_pkg::COLOR_WIDTH-1:0]  color_ff, color_in;
   logic                             last_ff, last_in;

   logic                load;
   logic                use_high;
   ngb_pkg::pixel_type  pix;
   logic [21:0]         product;

   always_comb begin
      load     = !empty && (!valid_ff || rsp_ready);
      // Take the high nibble once the low one is out or was clipped.
      use_high = sel_ff || !head.p0.hit;
      pix      = use_high ? head.p1 : head.p0;
      product  = 22'(pix.y) * 22'(fb_width) + 22'(pix.x);

      addr_in  = addr_ff;
      color_in = color_ff;
      last_in  = last_ff;
      sel_in   = sel_ff;
      valid_in = valid_ff && !rsp_ready;
      pop      = 1'b0;
      if (load) begin
         addr_in  = product[ngb_pkg::ADDR_WIDTH-1:0];
         color_in = palette[pix.nib];
         last_in  = use_high || !head.p1.hit;
         valid_in = 1'b1;
         pop      = last_in;
         sel_in   = !last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_color   = color_ff;
   assign rsp_last          = last_ff;

endmodule

// ----- hdl/ngb_checker.sv -----
// Port-level checks for the glyph blitter, bound to the top level.
// Depends on nibble_glyph_to_rgb565_blitter_unit and ngb_pkg.
module ngb_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [ngb_pkg::ADDR_WIDTH-1:0]        rsp_pixel_address,
   input logic [ngb_pkg::COLOR_WIDTH-1:0]       rsp_pixel_color,
   input logic                                  rsp_last
);

   // A stalled write holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_address)
         && $stable(rsp_pixel_color) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // Nothing is issued right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // The second pixel of a byte is already queued and follows at once.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("second pixel of a byte did not follow");

   // A full queue means the output register holds a write.
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending write");

endmodule

bind nibble_glyph_to_rgb565_blitter_unit ngb_checker u_ngb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pixel_address (rsp_pixel_address),
   .rsp_pixel_color   (rsp_pixel_color),
   .rsp_last          (rsp_last)
);

// ----- tb/nibble_glyph_to_rgb565_blitter_unit_test.sv -----
// Self-checking bench for nibble_glyph_to_rgb565_blitter_unit: random and directed
// glyph transactions, a transaction-level predictor of every frame-buffer write, and a scoreboard.
// Depends on ngb_pkg and the blitter RTL only.
module nibble_glyph_to_rgb565_blitter_unit_test;

   localparam int FB_CAP      = 131072;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   // One request transaction as it goes onto the req_* ports.
   typedef struct {
      logic               op;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [7:0]         glyph_width;
      logic [7:0]         glyph_height;
      logic signed [7:0]  baseline_offset;
      logic [7:0]         font_byte;
   } blit_request_type;

   // One frame-buffer write as it should appear on the rsp_* ports.
   typedef struct packed {
      logic [ngb_pkg::ADDR_WIDTH-1:0]  address;
      logic [ngb_pkg::COLOR_WIDTH-1:0] color;
      logic                            last;
   } pixel_write_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic                                  req_op = ngb_pkg::OP_HEADER;
   logic signed [15:0]                    req_origin_x = '0;
   logic signed [15:0]                    req_origin_y = '0;
   logic [7:0]                            req_glyph_width = '0;
   logic [7:0]                            req_glyph_height = '0;
   logic signed [7:0]                     req_baseline_offset = '0;
   logic [7:0]                            req_font_byte = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic [ngb_pkg::ADDR_WIDTH-1:0]        rsp_pixel_address;
   logic [ngb_pkg::COLOR_WIDTH-1:0]       rsp_pixel_color;
   logic                                  rsp_last;
   logic                                  csr_we = 1'b0;
   logic [ngb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index = ngb_pkg::CSR_FB_WIDTH;
   logic [63:0]                           csr_wdata = '0;

   nibble_glyph_to_rgb565_blitter_unit #(.FB_CAPACITY(FB_CAP)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_origin_x        (req_origin_x),
      .req_origin_y        (req_origin_y),
      .req_glyph_width     (req_glyph_width),
      .req_glyph_height    (req_glyph_height),
      .req_baseline_offset (req_baseline_offset),
      .req_font_byte       (req_font_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_address   (rsp_pixel_address),
      .rsp_pixel_color     (rsp_pixel_color),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Transactions waiting to be offered, and writes the predictor has promised.
   blit_request_type glyph_stream [$];
   pixel_write_type  writes_due [$];

   // Predictor copy of the configuration registers.
   logic [ngb_pkg::FB_DIM_WIDTH-1:0] fb_cols = '0;
   logic [ngb_pkg::FB_DIM_WIDTH-1:0] fb_rows = '0;
   logic [63:0]                      palette_word [4] = '{default: '0};

   // Predictor copy of the glyph state; col_at/row_at point at the next nibble.
   logic signed [15:0] glyph_left = '0;
   logic signed [16:0] glyph_top = '0;
   logic [7:0]         glyph_cols = '0;
   logic [7:0]         glyph_rows = '0;
   logic [7:0]         col_at = '0;
   logic [7:0]         row_at = '0;

   int               mismatch_count = 0;
   int               cycle_count = 0;
   logic             burst_mode = 1'b0;
   logic             want_hold = 1'b0;
   logic             offering;
   int               send_gap = 0;
   int               stall_left = 0;
   int               hold_left = 0;
   blit_request_type offered;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 92)
         return $urandom_range(4, 8);
      return $urandom_range(9, 30);
   endfunction

   // Advance the glyph state by one accepted transaction and queue the writes it causes.
   task automatic blit_transaction(input blit_request_type t);
      pixel_write_type got [2];
      int              produced;
      int              k;
      int              x;
      int              y;
      int              addr_full;
      longint          area;
      logic [3:0]      nib;
      produced = 0;
      if (t.op == ngb_pkg::OP_HEADER) begin
         glyph_left = t.origin_x;
         glyph_top  = 17'(int'(t.origin_y) + int'(t.baseline_offset));
         glyph_cols = t.glyph_width;
         glyph_rows = t.glyph_height;
         col_at     = '0;
         row_at     = '0;
         return;
      end
      for (k = 0; k < 2; k++) begin
         nib = (k == 0) ? t.font_byte[3:0] : t.font_byte[7:4];
         // Drop nibbles once the glyph is used up, or when it has no columns.
         if (row_at < glyph_rows && glyph_cols != 0) begin
            x    = int'(glyph_left) + int'(col_at);
            y    = int'(glyph_top) + int'(row_at);
            area = longint'(fb_cols) * longint'(fb_rows);
            // Clip on every edge, and suppress everything in an oversized frame.
            if (area <= FB_CAP && x >= 0 && y >= 0 && x < int'(fb_cols) &&
                y < int'(fb_rows)) begin
               addr_full = y * int'(fb_cols) + x;
               got[produced].address = addr_full[ngb_pkg::ADDR_WIDTH-1:0];
               got[produced].color   = palette_word[nib[3:2]][{nib[1:0], 4'b0000} +: 16];
               got[produced].last    = 1'b0;
               produced++;
            end
            col_at++;
            if (col_at >= glyph_cols) begin
               col_at = '0;
               row_at++;
            end
         end
      end
      for (k = 0; k < produced; k++) begin
         if (k == produced - 1)
            got[k].last = 1'b1;
         writes_due.push_back(got[k]);
      end
   endtask

   // Every field random; callers override the fields that matter for the kind.
   function automatic blit_request_type random_fill();
      blit_request_type t;
      t.op              = 1'($urandom);
      t.origin_x        = 16'($urandom);
      t.origin_y        = 16'($urandom);
      t.glyph_width     = 8'($urandom);
      t.glyph_height    = 8'($urandom);
      t.baseline_offset = 8'($urandom);
      t.font_byte       = 8'($urandom);
      return t;
   endfunction

   task automatic push_header(input int ox, input int oy, input int gw, input int gh,
                              input int bo);
      blit_request_type t;
      t                 = random_fill();
      t.op              = ngb_pkg::OP_HEADER;
      t.origin_x        = 16'(ox);
      t.origin_y        = 16'(oy);
      t.glyph_width     = 8'(gw);
      t.glyph_height    = 8'(gh);
      t.baseline_offset = 8'(bo);
      glyph_stream.push_back(t);
   endtask

   task automatic push_data(input logic [7:0] pixels);
      blit_request_type t;
      t           = random_fill();
      t.op        = ngb_pkg::OP_DATA;
      t.font_byte = pixels;
      glyph_stream.push_back(t);
   endtask

   // Write one register and mirror it in the predictor; the block is idle here.
   task automatic write_reg(input logic [ngb_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [63:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ngb_pkg::CSR_FB_WIDTH:         fb_cols = val[ngb_pkg::FB_DIM_WIDTH-1:0];
         ngb_pkg::CSR_FB_HEIGHT:        fb_rows = val[ngb_pkg::FB_DIM_WIDTH-1:0];
         ngb_pkg::CSR_PALETTE_LOW:      palette_word[0] = val;
         ngb_pkg::CSR_PALETTE_MID_LOW:  palette_word[1] = val;
         ngb_pkg::CSR_PALETTE_MID_HIGH: palette_word[2] = val;
         ngb_pkg::CSR_PALETTE_HIGH:     palette_word[3] = val;
         default: ;
      endcase
   endtask

   task automatic program_frame(input int cols, input int rows, input logic [63:0] p0,
                                input logic [63:0] p1, input logic [63:0] p2,
                                input logic [63:0] p3);
      write_reg(ngb_pkg::CSR_FB_WIDTH, 64'(cols));
      write_reg(ngb_pkg::CSR_FB_HEIGHT, 64'(rows));
      write_reg(ngb_pkg::CSR_PALETTE_LOW, p0);
      write_reg(ngb_pkg::CSR_PALETTE_MID_LOW, p1);
      write_reg(ngb_pkg::CSR_PALETTE_MID_HIGH, p2);
      write_reg(ngb_pkg::CSR_PALETTE_HIGH, p3);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Hold until every transaction is taken and every write has come back, then
   // let the pipeline settle so a trailing header or clipped byte is flushed too.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (glyph_stream.size() != 0 || req_valid || writes_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Queue whole glyphs with random content, plus some stray and broken sequences.
   task automatic queue_random_glyphs(input int target);
      int queued;
      int pick;
      int gw;
      int gh;
      int ox;
      int oy;
      int bo;
      int nbytes;
      int i;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            push_data(8'($urandom));
            queued++;
         end else begin
            if (pick < 14) begin
               ox = int'($urandom_range(0, 65535)) - 32768;
               oy = int'($urandom_range(0, 65535)) - 32768;
               bo = int'($urandom_range(0, 255)) - 128;
            end else begin
               bo = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, 8)) - 4
                                                 : int'($urandom_range(0, 255)) - 128;
               ox = int'($urandom_range(0, int'(fb_cols) + 16)) - 8;
               oy = int'($urandom_range(0, int'(fb_rows) + 16)) - 8 - bo;
            end
            pick = $urandom_range(0, 99);
            gw = (pick < 80) ? $urandom_range(0, 10) :
                 (pick < 95) ? $urandom_range(11, 40) : $urandom_range(200, 255);
            pick = $urandom_range(0, 99);
            gh = (pick < 85) ? $urandom_range(0, 10) :
                 (pick < 97) ? $urandom_range(11, 30) : $urandom_range(200, 255);
            nbytes = (gw * gh + 1) / 2;
            // Cut large glyphs short so the run stays brief.
            if (nbytes > 40)
               nbytes = $urandom_range(1, 40);
            // Now and then truncate or overrun the sequence.
            if ($urandom_range(0, 9) == 0)
               nbytes = $urandom_range(0, nbytes + 3);
            push_header(ox, oy, gw, gh, bo);
            for (i = 0; i < nbytes; i++)
               push_data(8'($urandom));
            queued += 1 + nbytes;
         end
      end
   endtask

   // Driver: offer one transaction at a time, hold it until accepted, then idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            blit_transaction(offered);
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (glyph_stream.size() != 0) begin
               offered = glyph_stream.pop_front();
               req_valid           <= 1'b1;
               req_op              <= offered.op;
               req_origin_x        <= offered.origin_x;
               req_origin_y        <= offered.origin_y;
               req_glyph_width     <= offered.glyph_width;
               req_glyph_height    <= offered.glyph_height;
               req_baseline_offset <= offered.baseline_offset;
               req_font_byte       <= offered.font_byte;
               send_gap = (burst_mode || $urandom_range(0, 2) != 0) ? 0 : idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: score each accepted write against the oldest prediction, then
   // decide the next cycle's ready, including the one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (writes_due.size() == 0) begin
               $display("%0t: unexpected write, address %h color %h last %b", $time,
                        rsp_pixel_address, rsp_pixel_color, rsp_last);
               mismatch_count++;
            end else begin
               if (rsp_pixel_address !== writes_due[0].address) begin
                  $display("%0t: pixel_address expected %h got %h", $time,
                           writes_due[0].address, rsp_pixel_address);
                  mismatch_count++;
               end
               if (rsp_pixel_color !== writes_due[0].color) begin
                  $display("%0t: pixel_color expected %h got %h", $time,
                           writes_due[0].color, rsp_pixel_color);
                  mismatch_count++;
               end
               if (rsp_last !== writes_due[0].last) begin
                  $display("%0t: last expected %b got %b", $time,
                           writes_due[0].last, rsp_last);
                  mismatch_count++;
               end
               void'(writes_due.pop_front());
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (want_hold) begin
            want_hold = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!burst_mode && $urandom_range(0, 3) == 0)
               stall_left = idle_span();
         end
      end
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part on a small 16x12 frame.
      program_frame(16, 12, random_word(), random_word(), random_word(), random_word());
      push_data(8'hA5);                    // data before any header: ignored
      push_header(-1, -2, 3, 3, 1);        // clip left and top edges
      push_data(8'h10);
      push_data(8'h32);
      push_data(8'h54);
      push_data(8'h76);
      push_data(8'h98);                    // high nibble falls past the glyph
      push_header(14, 10, 4, 3, 0);        // clip right and bottom edges
      push_data(8'hFE);
      push_data(8'hDC);
      push_data(8'hBA);
      push_data(8'h00);
      push_data(8'hFF);
      push_data(8'h21);
      push_header(2, 2, 0, 5, 0);          // zero width swallows data
      push_data(8'hFF);
      push_header(2, 2, 5, 0, 0);          // zero height swallows data
      push_data(8'h0F);
      push_header(32767, -32768, 255, 255, -128);
      push_data(8'hFF);
      push_header(-32768, 32767, 1, 1, 127);
      push_data(8'h00);
      push_header(0, 0, 1, 2, 0);          // one byte spans two rows
      push_data(8'hF0);
      wait_quiet();

      // Frame exactly at capacity; the receiver holds off long enough to back up the input.
      program_frame(1024, 128, random_word(), random_word(), random_word(), random_word());
      want_hold = 1'b1;
      queue_random_glyphs(100);
      wait_quiet();

      // Oversized frame: nothing may be written.
      program_frame(1024, 1024, '1, '1, '1, '1);
      queue_random_glyphs(40);
      wait_quiet();

      // Empty frame: every pixel is outside.
      program_frame(0, 0, random_word(), random_word(), random_word(), random_word());
      queue_random_glyphs(30);
      wait_quiet();

      // Back-to-back traffic on both sides.
      burst_mode = 1'b1;
      program_frame(37, 23, '1, '1, '1, '1);
      queue_random_glyphs(100);
      wait_quiet();
      burst_mode = 1'b0;

      program_frame($urandom_range(1, 64), $urandom_range(1, 64), '0, '0, '0, '0);
      queue_random_glyphs(80);
      wait_quiet();

      // Tall frame exactly at capacity.
      program_frame(128, 1024, random_word(), random_word(), random_word(), random_word());
      queue_random_glyphs(50);
      wait_quiet();

      if (mismatch_count == 0 && writes_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
